>>> rtl/mbdd_pkg.sv
// Shared constants, codes and handshake types of the multiplexed BCD display driver.
`default_nettype none

package mbdd_pkg;

    localparam int MAX_DIGITS_DEF = 8;

    localparam int NUMBER_W   = 32;
    localparam int BCD_DIGITS = 10;
    localparam int NIBBLE_W   = 4;
    localparam int BIT_CNT_W  = $clog2(NUMBER_W);
    localparam int COUNT_W    = 4;
    localparam int DWELL_W    = 16;
    localparam int SEL_W      = 8;
    localparam int INDEX_W    = 3;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [NIBBLE_W-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [NIBBLE_W-1:0] DABBLE_ADD   = 4'd3;

    localparam logic [COUNT_W-1:0] DIGIT_COUNT_RST = 4'd3;
    localparam logic [DWELL_W-1:0] DWELL_TICKS_RST = 16'd5;

    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL_TICKS = 1'b1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CONV   = 4'b0010,
        ST_COMMIT = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    typedef struct packed {
        logic take_tick;
        logic take_load;
        logic conv_step;
        logic conv_commit;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic conv_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/multiplexed_bcd_display_driver_unit.sv
// Top level of the multiplexed BCD display driver: config registers, sequencer and datapath.
// Tick word: dwell counter and scan index advance on acceptance; the result state then loads
// the output register once it is free. Load word: conversion of all 32 bits (one bit per cycle
// of the shift-add-3 unit), a store commit state, then the result state as for a tick word.
// One word in flight; a finished result may wait in the output register while the next is taken.
// Synchronous active-low reset clears the store, scan index and dwell counter and sets
// digit_count to 3 and dwell_ticks to 5.
`default_nettype none

module multiplexed_bcd_display_driver_unit
    import mbdd_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] number
    input  wire logic                  s_tuser,   // [0] command
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [3:0] bcd_value, [11:4] digit_select,
                                                  // [14:12] digit_index, [15] zero
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [COUNT_W-1:0] digit_count_reg;
    logic [DWELL_W-1:0] dwell_ticks_reg;
    ctrl_cmd_t          cmd;
    dp_status_t         status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_count_reg <= DIGIT_COUNT_RST;
            dwell_ticks_reg <= DWELL_TICKS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_DIGIT_COUNT: digit_count_reg <= cfg_data[COUNT_W-1:0];
                REG_DWELL_TICKS: dwell_ticks_reg <= cfg_data[DWELL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mbdd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .command  (s_tuser),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    mbdd_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .number      (s_tdata[NUMBER_W-1:0]),
        .digit_count (digit_count_reg),
        .dwell_ticks (dwell_ticks_reg),
        .m_tready    (m_tready),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire

>>> rtl/mbdd_ctrl.sv
// Sequencer of the display driver: accepts words, runs the conversion, issues results.
`default_nettype none

module mbdd_ctrl
    import mbdd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic       command,
    input  wire dp_status_t status,
    output logic            s_tready,
    output ctrl_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (command == CMD_TICK) begin
                        cmd.take_tick = 1'b1;
                        state_next    = ST_RESULT;
                    end else begin
                        cmd.take_load = 1'b1;
                        state_next    = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                cmd.conv_step = 1'b1;
                if (status.conv_last) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.conv_commit = 1'b1;
                state_next      = ST_RESULT;
            end
            ST_RESULT: begin
                // hold until the output register is free
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/mbdd_datapath.sv
// Datapath: shift-add-3 converter, digit store, scan and dwell counters, output register.
`default_nettype none

module mbdd_datapath
    import mbdd_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire ctrl_cmd_t            cmd,
    input  wire logic [NUMBER_W-1:0]  number,
    input  wire logic [COUNT_W-1:0]   digit_count,
    input  wire logic [DWELL_W-1:0]   dwell_ticks,
    input  wire logic                 m_tready,
    output dp_status_t                status,
    output logic                      m_tvalid,
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    logic [NUMBER_W-1:0]                      number_reg,  number_next;
    logic [BCD_DIGITS-1:0][NIBBLE_W-1:0]      bcd_reg,     bcd_next;
    logic [BIT_CNT_W-1:0]                     bit_cnt_reg, bit_cnt_next;
    logic [NIBBLE_W-1:0]                      digit_reg  [MAX_DIGITS];
    logic [NIBBLE_W-1:0]                      digit_next [MAX_DIGITS];
    logic [IDX_W-1:0]                         scan_reg,    scan_next;
    logic [DWELL_W-1:0]                       dwell_reg,   dwell_next;
    logic                                     m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]                     m_tdata_reg,  m_tdata_next;

    logic [CNT_W-1:0]                         n_use;
    logic [DWELL_W-1:0]                       limit;
    logic [IDX_W-1:0]                         scan_clamped;
    logic [CNT_W-1:0]                         scan_inc;
    logic [DWELL_W-1:0]                       dwell_inc;
    logic [BCD_DIGITS-1:0][NIBBLE_W-1:0]      bcd_adj;
    logic [BCD_DIGITS*NIBBLE_W-1:0]           bcd_adj_flat;
    logic [MAX_DIGITS-1:0]                    select_onehot;

    // saturate the digit count into 1..MAX_DIGITS
    always_comb begin
        if (digit_count == '0) begin
            n_use = CNT_W'(1);
        end else if (32'(digit_count) > MAX_DIGITS) begin
            n_use = CNT_W'(MAX_DIGITS);
        end else begin
            n_use = CNT_W'(digit_count);
        end
        limit = (dwell_ticks == '0) ? DWELL_W'(1) : dwell_ticks;
    end

    always_comb begin
        scan_clamped = (CNT_W'(scan_reg) >= n_use) ? '0 : scan_reg;
        dwell_inc    = dwell_reg + DWELL_W'(1);
        scan_inc     = CNT_W'(scan_clamped) + CNT_W'(1);
    end

    // one shift-add-3 step: correct every nibble, then shift in the next bit
    always_comb begin
        for (int d = 0; d < BCD_DIGITS; d++) begin
            bcd_adj[d] = (bcd_reg[d] >= DABBLE_LIMIT) ? bcd_reg[d] + DABBLE_ADD : bcd_reg[d];
        end
        bcd_adj_flat = bcd_adj;
    end

    always_comb begin
        number_next  = number_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        scan_next    = scan_reg;
        dwell_next   = dwell_reg;
        for (int p = 0; p < MAX_DIGITS; p++) begin
            digit_next[p] = digit_reg[p];
        end

        if (cmd.take_load) begin
            number_next  = number;
            bcd_next     = '0;
            bit_cnt_next = '0;
        end

        if (cmd.conv_step) begin
            bcd_next     = {bcd_adj_flat[BCD_DIGITS*NIBBLE_W-2:0], number_reg[NUMBER_W-1]};
            number_next  = {number_reg[NUMBER_W-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
        end

        // last digit in use takes the least significant decimal digit
        if (cmd.conv_commit) begin
            for (int p = 0; p < MAX_DIGITS; p++) begin
                if (p < 32'(n_use)) begin
                    digit_next[p] = bcd_reg[4'(32'(n_use) - 1 - p)];
                end else begin
                    digit_next[p] = '0;
                end
            end
            scan_next  = '0;
            dwell_next = '0;
        end

        if (cmd.take_tick) begin
            if (dwell_inc >= limit) begin
                dwell_next = '0;
                scan_next  = (scan_inc >= n_use) ? '0 : IDX_W'(scan_inc);
            end else begin
                dwell_next = dwell_inc;
                scan_next  = scan_clamped;
            end
        end
    end

    always_comb begin
        select_onehot = MAX_DIGITS'(1) << scan_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {1'b0, INDEX_W'(scan_reg), SEL_W'(select_onehot),
                             digit_reg[scan_reg]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg     <= '0;
            dwell_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            for (int p = 0; p < MAX_DIGITS; p++) begin
                digit_reg[p] <= '0;
            end
        end else begin
            scan_reg     <= scan_next;
            dwell_reg    <= dwell_next;
            m_tvalid_reg <= m_tvalid_next;
            for (int p = 0; p < MAX_DIGITS; p++) begin
                digit_reg[p] <= digit_next[p];
            end
        end
    end

    always_ff @(posedge aclk) begin
        number_reg  <= number_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign status.conv_last = (bit_cnt_reg == BIT_CNT_W'(NUMBER_W - 1));
    assign status.out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid         = m_tvalid_reg;
    assign m_tdata          = m_tdata_reg;

endmodule

`default_nettype wire

>>> rtl/mbdd_checker.sv
// Port-level checker of the display driver and its bind to the top level.
`default_nettype none

module mbdd_checker
    import mbdd_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_bcd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[3:0] <= 4'd9)
        else $error("digit outside 0..9");

    a_select_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[11:4] == (8'd1 << m_tdata[14:12]))
        else $error("digit select does not match digit index");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind multiplexed_bcd_display_driver_unit mbdd_checker u_mbdd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
